FILE: rtl/sbc_pkg.sv
// Shared types, constants and round functions for the SHA-512 compression unit.
package sbc_pkg;

    localparam int WordW   = 64;
    localparam int Rounds  = 80;
    localparam int QDepth  = 4;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ABSORB = 1'b1;

    typedef logic [WordW-1:0] word_t;

    // Item passed from the front end to the compression engine.
    typedef struct packed {
        logic       opcode;
        logic [2:0] word_index;
        word_t      data_word;
    } item_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic word_t round_k(input logic [6:0] t);
        word_t k;
        begin
            case (t)
                7'd0:  k = 64'h428A2F98D728AE22; 7'd1:  k = 64'h7137449123EF65CD;
                7'd2:  k = 64'hB5C0FBCFEC4D3B2F; 7'd3:  k = 64'hE9B5DBA58189DBBC;
                7'd4:  k = 64'h3956C25BF348B538; 7'd5:  k = 64'h59F111F1B605D019;
                7'd6:  k = 64'h923F82A4AF194F9B; 7'd7:  k = 64'hAB1C5ED5DA6D8118;
                7'd8:  k = 64'hD807AA98A3030242; 7'd9:  k = 64'h12835B0145706FBE;
                7'd10: k = 64'h243185BE4EE4B28C; 7'd11: k = 64'h550C7DC3D5FFB4E2;
                7'd12: k = 64'h72BE5D74F27B896F; 7'd13: k = 64'h80DEB1FE3B1696B1;
                7'd14: k = 64'h9BDC06A725C71235; 7'd15: k = 64'hC19BF174CF692694;
                7'd16: k = 64'hE49B69C19EF14AD2; 7'd17: k = 64'hEFBE4786384F25E3;
                7'd18: k = 64'h0FC19DC68B8CD5B5; 7'd19: k = 64'h240CA1CC77AC9C65;
                7'd20: k = 64'h2DE92C6F592B0275; 7'd21: k = 64'h4A7484AA6EA6E483;
                7'd22: k = 64'h5CB0A9DCBD41FBD4; 7'd23: k = 64'h76F988DA831153B5;
                7'd24: k = 64'h983E5152EE66DFAB; 7'd25: k = 64'hA831C66D2DB43210;
                7'd26: k = 64'hB00327C898FB213F; 7'd27: k = 64'hBF597FC7BEEF0EE4;
                7'd28: k = 64'hC6E00BF33DA88FC2; 7'd29: k = 64'hD5A79147930AA725;
                7'd30: k = 64'h06CA6351E003826F; 7'd31: k = 64'h142929670A0E6E70;
                7'd32: k = 64'h27B70A8546D22FFC; 7'd33: k = 64'h2E1B21385C26C926;
                7'd34: k = 64'h4D2C6DFC5AC42AED; 7'd35: k = 64'h53380D139D95B3DF;
                7'd36: k = 64'h650A73548BAF63DE; 7'd37: k = 64'h766A0ABB3C77B2A8;
                7'd38: k = 64'h81C2C92E47EDAEE6; 7'd39: k = 64'h92722C851482353B;
                7'd40: k = 64'hA2BFE8A14CF10364; 7'd41: k = 64'hA81A664BBC423001;
                7'd42: k = 64'hC24B8B70D0F89791; 7'd43: k = 64'hC76C51A30654BE30;
                7'd44: k = 64'hD192E819D6EF5218; 7'd45: k = 64'hD69906245565A910;
                7'd46: k = 64'hF40E35855771202A; 7'd47: k = 64'h106AA07032BBD1B8;
                7'd48: k = 64'h19A4C116B8D2D0C8; 7'd49: k = 64'h1E376C085141AB53;
                7'd50: k = 64'h2748774CDF8EEB99; 7'd51: k = 64'h34B0BCB5E19B48A8;
                7'd52: k = 64'h391C0CB3C5C95A63; 7'd53: k = 64'h4ED8AA4AE3418ACB;
                7'd54: k = 64'h5B9CCA4F7763E373; 7'd55: k = 64'h682E6FF3D6B2B8A3;
                7'd56: k = 64'h748F82EE5DEFB2FC; 7'd57: k = 64'h78A5636F43172F60;
                7'd58: k = 64'h84C87814A1F0AB72; 7'd59: k = 64'h8CC702081A6439EC;
                7'd60: k = 64'h90BEFFFA23631E28; 7'd61: k = 64'hA4506CEBDE82BDE9;
                7'd62: k = 64'hBEF9A3F7B2C67915; 7'd63: k = 64'hC67178F2E372532B;
                7'd64: k = 64'hCA273ECEEA26619C; 7'd65: k = 64'hD186B8C721C0C207;
                7'd66: k = 64'hEADA7DD6CDE0EB1E; 7'd67: k = 64'hF57D4F7FEE6ED178;
                7'd68: k = 64'h06F067AA72176FBA; 7'd69: k = 64'h0A637DC5A2C898A6;
                7'd70: k = 64'h113F9804BEF90DAE; 7'd71: k = 64'h1B710B35131C471B;
                7'd72: k = 64'h28DB77F523047D84; 7'd73: k = 64'h32CAAB7B40C72493;
                7'd74: k = 64'h3C9EBE0A15C9BEBC; 7'd75: k = 64'h431D67C49C100D4C;
                7'd76: k = 64'h4CC5D4BECB3E42B6; 7'd77: k = 64'h597F299CFC657E2A;
                7'd78: k = 64'h5FCB6FAB3AD6FAEC; 7'd79: k = 64'h6C44198C4A475817;
                default: k = '0;
            endcase
            round_k = k;
        end
    endfunction

endpackage

FILE: rtl/sbc_front.sv
// Input front end: holds unpacked stream items in a small item queue.
module sbc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sbc_pkg::item_t       in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output sbc_pkg::item_t       q_item
);
    import sbc_pkg::*;

    localparam int PtrW = $clog2(QDepth);

    item_t           mem [QDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready = (count_reg != (PtrW+1)'(QDepth));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/sbc_engine.sv
// Compression engine: chaining/message storage, one round per cycle, digest output.
module sbc_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  sbc_pkg::item_t       q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sbc_pkg::word_t       out_word,
    output logic [2:0]           out_index,
    output logic                 out_last
);
    import sbc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [3:0] wcount_reg;
    logic [6:0] round_reg;
    logic [2:0] emit_reg;
    logic       ovalid_reg;

    word_t cv_reg [8];
    word_t w_reg  [16];   // shift line: w_reg[0] is the oldest schedule word
    word_t v_reg  [8];

    word_t wt, s0, s1, t1, t2, e, a;
    logic  accept;

    assign accept  = (state_reg == ST_IDLE) && q_valid;
    assign q_ready = (state_reg == ST_IDLE);

    assign a  = v_reg[0];
    assign e  = v_reg[4];
    assign s0 = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
    assign s1 = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
    // first 16 rounds use stored words; later ones the expanded word
    assign wt = (round_reg < 7'd16) ? w_reg[0] : (s1 + w_reg[9] + s0 + w_reg[0]);
    assign t1 = v_reg[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(round_reg) + wt;
    assign t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign out_valid = ovalid_reg;
    assign out_word  = cv_reg[emit_reg];
    assign out_index = emit_reg;
    assign out_last  = (emit_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        if (accept && q_item.opcode == OP_LOAD)
            cv_reg[q_item.word_index] <= q_item.data_word;
        if (accept && q_item.opcode == OP_ABSORB)
            w_reg[wcount_reg] <= q_item.data_word;
        if (state_reg == ST_IDLE)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= cv_reg[i];
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == ST_ADD)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= cv_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wcount_reg <= '0;
            round_reg  <= '0;
            emit_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && q_item.opcode == OP_ABSORB)
                    begin
                        wcount_reg <= wcount_reg + 1'b1;
                        if (wcount_reg == 4'd15)
                        begin
                            state_reg <= ST_ROUND;
                            round_reg <= '0;
                        end
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 7'(Rounds - 1))
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    state_reg  <= ST_EMIT;
                    emit_reg   <= '0;
                    ovalid_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg == 3'd7)
                        begin
                            ovalid_reg <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/sha512_block_compress_unit.sv
// Top level of the SHA-512 block compression unit.
//
// Usage:
//   s_axis carries one transaction per load or absorb. tuser is the opcode
//   (0 = load chaining word, 1 = absorb message word); tdata holds
//   word_index in bits [2:0] and data_word in bits [66:3], zero filled to 72.
//   Load all eight chaining words before the first absorb of a block.
//   m_axis delivers eight digest words after every sixteenth absorb:
//   tdata = digest_word, tuser = digest_index, tlast on index 7.
// Timing:
//   A four-entry queue takes input while the engine is busy. Loads and
//   non-final absorbs retire while the engine is idle. The sixteenth absorb
//   starts the rounds (one round per cycle in the engine), then the add step,
//   then eight output transactions, one per cycle when m_axis_tready is high.
//   A block runs as 16 absorbs, the rounds, the add and 8 outputs, in order.
// Reset: rst_n clears the queue, word counter and engine state; stored
//   chaining and message words are not cleared.
// Backpressure: a stalled m_axis holds the current digest word; the engine
//   waits and the input queue fills, then s_axis_tready drops.
module sha512_block_compress_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // word_index[2:0], data_word[66:3], zero pad
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // digest_index
    output logic        m_axis_tlast    // last_word
);
    import sbc_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item.opcode     = s_axis_tuser;
    assign in_item.word_index = s_axis_tdata[2:0];
    assign in_item.data_word  = s_axis_tdata[66:3];

    sbc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    sbc_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_index (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
